/* sv/conv3x3_pkg.sv */
// ---------------------------------------------------------------------------
// conv3x3_pkg
// Shared types and constants for the zero-padded 3x3 convolution block.
// ---------------------------------------------------------------------------
package conv3x3_pkg;

   // Default line buffer depth and frame height limit.
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   // Field widths fixed by the interface.
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int FRAC_BITS  = 12;
   localparam int POS_W      = 10;
   localparam int RESULT_W   = 16;
   localparam int DIM_W      = 11;
   localparam int CSR_DATA_W = 3 * COEF_W;
   localparam int CSR_IDX_W  = 3;

   // Arithmetic widths: one product, a row of three, all nine.
   localparam int PROD_W   = PIX_W + COEF_W;
   localparam int ROWSUM_W = PROD_W + 2;
   localparam int SUM_W    = PROD_W + 4;

   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SAT_MIN    = -SUM_W'(32768);
   localparam logic signed [RESULT_W-1:0] RESULT_MAX = 16'sh7fff;
   localparam logic signed [RESULT_W-1:0] RESULT_MIN = 16'sh8000;

   // Register reset values.
   localparam logic [DIM_W-1:0]      FRAME_WIDTH_RESET  = DIM_W'(1024);
   localparam logic [DIM_W-1:0]      FRAME_HEIGHT_RESET = DIM_W'(1024);
   localparam logic [CSR_DATA_W-1:0] KERNEL_TOP_RESET   = '0;
   localparam logic [CSR_DATA_W-1:0] KERNEL_MID_RESET   = CSR_DATA_W'(4096);
   localparam logic [CSR_DATA_W-1:0] KERNEL_BOT_RESET   = '0;

   // Result queue.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int PIPE_STAGES = 4;
   localparam int OCC_W     = $clog2(RSP_DEPTH + PIPE_STAGES + 1);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_KERNEL_TOP    = 3'd2,
      CSR_KERNEL_MIDDLE = 3'd3,
      CSR_KERNEL_BOTTOM = 3'd4
   } csr_index_type;

   // Per-request control that travels beside the data path.
   typedef struct packed {
      logic             emit;
      logic             last;
      logic             row_top_ok;
      logic             row_bot_ok;
      logic             col_left_ok;
      logic             col_right_ok;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
   } stage_ctrl_type;

   // One queued result.
   typedef struct packed {
      logic signed [RESULT_W-1:0] filtered_value;
      logic [POS_W-1:0]           out_column;
      logic [POS_W-1:0]           out_row;
      logic                       frame_last;
   } result_type;

endpackage

/* sv/convolution_3x3_zero_padded.sv */
// ---------------------------------------------------------------------------
// convolution_3x3_zero_padded
// Zero-padded 3x3 convolution over a raster pixel stream, two line buffers
// in one read-modify-write memory, signed Q3.12 kernel, rounded and saturated.
// ---------------------------------------------------------------------------
// Throughput: one request per cycle while req_ready is high, set by the single
// line buffer memory, which is read and written back once per request.
// Output: a result passes the pipeline stages and the result queue once the request
// that completes its window is accepted (the result for pixel k comes with request k+W+1).
// Reset: synchronous; registers return to defaults and position counters to
// zero. The line buffers are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module convolution_3x3_zero_padded #(
   parameter int MAX_WIDTH  = conv3x3_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = conv3x3_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [conv3x3_pkg::PIX_W-1:0]            req_pixel_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [conv3x3_pkg::RESULT_W-1:0]  rsp_filtered_value,
   output logic [conv3x3_pkg::POS_W-1:0]            rsp_out_column,
   output logic [conv3x3_pkg::POS_W-1:0]            rsp_out_row,
   output logic                                     rsp_frame_last,
   input  logic                                     csr_write_enable,
   input  logic [conv3x3_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [conv3x3_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
   localparam int WID_W  = ($clog2(MAX_WIDTH + 1) > conv3x3_pkg::DIM_W) ?
                           $clog2(MAX_WIDTH + 1) : conv3x3_pkg::DIM_W;
   localparam int HGT_W  = ($clog2(MAX_HEIGHT + 2) > conv3x3_pkg::DIM_W) ?
                           $clog2(MAX_HEIGHT + 2) : conv3x3_pkg::DIM_W;
   localparam int PIX_W  = conv3x3_pkg::PIX_W;
   localparam int COEF_W = conv3x3_pkg::COEF_W;
   localparam int LINE_W = 2 * PIX_W;

   // Configuration registers.
   logic [conv3x3_pkg::DIM_W-1:0]      frame_width_ff;
   logic [conv3x3_pkg::DIM_W-1:0]      frame_height_ff;
   logic [conv3x3_pkg::CSR_DATA_W-1:0] kernel_ff [0:2];

   // Position counters.
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   // Request stage signals.
   logic                        accept;
   logic [WID_W-1:0]            w_eff;
   logic [HGT_W-1:0]            h_eff;
   logic [COL_W-1:0]            col_sel;
   logic                        col_wrap;
   logic                        out_col_wrap;
   logic [PIX_W-1:0]            px0;
   conv3x3_pkg::stage_ctrl_type ctrl0;

   // Pipeline registers.
   logic                        v1_ff, v2_ff, v3_ff, v4_ff;
   conv3x3_pkg::stage_ctrl_type s1_ctrl_ff, s2_ctrl_ff, s3_ctrl_ff, s4_ctrl_ff;
   logic [COL_W-1:0]            addr1_ff;
   logic [PIX_W-1:0]            px1_ff;

   // Line buffer memory: low byte is two rows up, high byte one row up.
   logic [LINE_W-1:0] line_mem [0:MAX_WIDTH-1];
   logic [LINE_W-1:0] rd_ff;
   logic              fwd_hit_ff;
   logic [LINE_W-1:0] fwd_data_ff;
   logic [LINE_W-1:0] col_data;
   logic [LINE_W-1:0] mem_wr_data;
   logic [PIX_W-1:0]  up1, up2;

   // Window and arithmetic.
   logic [PIX_W-1:0]                          win_ff [0:2][0:2];
   logic signed [conv3x3_pkg::PROD_W-1:0]     prod_in [0:2][0:2];
   logic signed [conv3x3_pkg::PROD_W-1:0]     prod_ff [0:2][0:2];
   logic signed [conv3x3_pkg::ROWSUM_W-1:0]   rowsum_in [0:2];
   logic signed [conv3x3_pkg::ROWSUM_W-1:0]   rowsum_ff [0:2];
   logic signed [conv3x3_pkg::SUM_W-1:0]      total;
   logic signed [conv3x3_pkg::SUM_W-1:0]      shifted;
   logic signed [conv3x3_pkg::RESULT_W-1:0]   result_value;

   // Result queue.
   conv3x3_pkg::result_type                 fifo_ff [0:conv3x3_pkg::RSP_DEPTH-1];
   conv3x3_pkg::result_type                 push_data;
   logic [conv3x3_pkg::RSP_PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [conv3x3_pkg::RSP_CNT_W-1:0]       count_ff;
   logic [conv3x3_pkg::OCC_W-1:0]           occupancy;
   logic                                    push, pop;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= conv3x3_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= conv3x3_pkg::FRAME_HEIGHT_RESET;
         kernel_ff[0]    <= conv3x3_pkg::KERNEL_TOP_RESET;
         kernel_ff[1]    <= conv3x3_pkg::KERNEL_MID_RESET;
         kernel_ff[2]    <= conv3x3_pkg::KERNEL_BOT_RESET;
      end else if (csr_write_enable) begin
         case (conv3x3_pkg::csr_index_type'(csr_index))
            conv3x3_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_write_data[conv3x3_pkg::DIM_W-1:0];
            end
            conv3x3_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_write_data[conv3x3_pkg::DIM_W-1:0];
            end
            conv3x3_pkg::CSR_KERNEL_TOP:    kernel_ff[0] <= csr_write_data;
            conv3x3_pkg::CSR_KERNEL_MIDDLE: kernel_ff[1] <= csr_write_data;
            conv3x3_pkg::CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Effective frame size, clamped to the supported range.
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (WID_W'(frame_width_ff) > WID_W'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         h_eff = HGT_W'(1);
      end else if (HGT_W'(frame_height_ff) > HGT_W'(MAX_HEIGHT)) begin
         h_eff = HGT_W'(MAX_HEIGHT);
      end else begin
         h_eff = HGT_W'(frame_height_ff);
      end
   end

   // The pipeline never stalls, so space is reserved in the queue for
   // every request still in flight.
   assign occupancy = conv3x3_pkg::OCC_W'(count_ff) + conv3x3_pkg::OCC_W'(v1_ff)
                    + conv3x3_pkg::OCC_W'(v2_ff) + conv3x3_pkg::OCC_W'(v3_ff)
                    + conv3x3_pkg::OCC_W'(v4_ff);
   assign req_ready = occupancy < conv3x3_pkg::OCC_W'(conv3x3_pkg::RSP_DEPTH);
   assign accept    = req_valid && req_ready;

   // Request stage: column select, flags and zero-padding masks.
   always_comb begin
      if (WID_W'(in_col_ff) >= w_eff) begin
         col_sel = COL_W'(w_eff - WID_W'(1));
      end else begin
         col_sel = in_col_ff;
      end
      col_wrap     = (WID_W'(col_sel) + WID_W'(1)) >= w_eff;
      out_col_wrap = (WID_W'(out_col_ff) + WID_W'(1)) >= w_eff;
      px0 = (HGT_W'(in_row_ff) >= h_eff) ? '0 : req_pixel_value;

      ctrl0.emit = (in_row_ff >= ROW_W'(2)) ||
                   ((in_row_ff == ROW_W'(1)) && (col_sel != '0));
      ctrl0.last = HGT_W'(in_row_ff) >= (h_eff + HGT_W'(1));
      ctrl0.row_top_ok   = out_row_ff != '0;
      ctrl0.row_bot_ok   = (HGT_W'(out_row_ff) + HGT_W'(1)) < h_eff;
      ctrl0.col_left_ok  = out_col_ff != '0;
      ctrl0.col_right_ok = !out_col_wrap;
      ctrl0.column = conv3x3_pkg::POS_W'(out_col_ff);
      ctrl0.row    = conv3x3_pkg::POS_W'(out_row_ff);
   end

   // Next input and output positions.
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = col_sel + COL_W'(1);
         end
         if (ctrl0.emit) begin
            if (ctrl0.last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   // Control registers of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         v1_ff      <= accept;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         // The request in stage 1 writes this entry at the same edge.
         fwd_hit_ff <= accept && v1_ff && (addr1_ff == col_sel);
      end
   end

   // Payload registers that follow each request.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= ctrl0;
         addr1_ff   <= col_sel;
         px1_ff     <= px0;
      end
      fwd_data_ff <= mem_wr_data;
      s2_ctrl_ff  <= s1_ctrl_ff;
      s3_ctrl_ff  <= s2_ctrl_ff;
      s4_ctrl_ff  <= s3_ctrl_ff;
   end

   // Line buffer read-modify-write: read at acceptance, write back in stage 1.
   always_ff @(posedge clock) begin
      if (v1_ff) begin
         line_mem[addr1_ff] <= mem_wr_data;
      end
      if (accept) begin
         rd_ff <= line_mem[col_sel];
      end
   end

   // Stage 1: new window column, one row shifted up into the older buffer.
   assign col_data    = fwd_hit_ff ? fwd_data_ff : rd_ff;
   assign up2         = col_data[PIX_W-1:0];
   assign up1         = col_data[LINE_W-1:PIX_W];
   assign mem_wr_data = {px1_ff, up1};

   // Window shift register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[r][k] <= '0;
            end
         end
      end else if (v1_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= up2;
         win_ff[1][2] <= up1;
         win_ff[2][2] <= px1_ff;
      end
   end

   // Stage 2: nine masked products; taps outside the image count as zero.
   always_comb begin
      logic row_ok [0:2];
      logic col_ok [0:2];
      row_ok[0] = s2_ctrl_ff.row_top_ok;
      row_ok[1] = 1'b1;
      row_ok[2] = s2_ctrl_ff.row_bot_ok;
      col_ok[0] = s2_ctrl_ff.col_left_ok;
      col_ok[1] = 1'b1;
      col_ok[2] = s2_ctrl_ff.col_right_ok;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            if (row_ok[r] && col_ok[k]) begin
               prod_in[r][k] =
                  $signed(conv3x3_pkg::PROD_W'(win_ff[r][k])) *
                  conv3x3_pkg::PROD_W'($signed(kernel_ff[r][COEF_W*k +: COEF_W]));
            end else begin
               prod_in[r][k] = '0;
            end
         end
      end
   end

   // Stage 3: row sums.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rowsum_in[r] = conv3x3_pkg::ROWSUM_W'(prod_ff[r][0])
                      + conv3x3_pkg::ROWSUM_W'(prod_ff[r][1])
                      + conv3x3_pkg::ROWSUM_W'(prod_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      rowsum_ff <= rowsum_in;
   end

   // Stage 4: total, round half up, drop the fraction, saturate.
   always_comb begin
      total = conv3x3_pkg::SUM_W'(rowsum_ff[0]) + conv3x3_pkg::SUM_W'(rowsum_ff[1])
            + conv3x3_pkg::SUM_W'(rowsum_ff[2]) + conv3x3_pkg::ROUND_BIAS;
      shifted = total >>> conv3x3_pkg::FRAC_BITS;
      if (shifted > conv3x3_pkg::SAT_MAX) begin
         result_value = conv3x3_pkg::RESULT_MAX;
      end else if (shifted < conv3x3_pkg::SAT_MIN) begin
         result_value = conv3x3_pkg::RESULT_MIN;
      end else begin
         result_value = shifted[conv3x3_pkg::RESULT_W-1:0];
      end
      push_data.filtered_value = result_value;
      push_data.out_column     = s4_ctrl_ff.column;
      push_data.out_row        = s4_ctrl_ff.row;
      push_data.frame_last     = s4_ctrl_ff.last;
   end

   // Result queue.
   assign push = v4_ff && s4_ctrl_ff.emit;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + conv3x3_pkg::RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + conv3x3_pkg::RSP_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + conv3x3_pkg::RSP_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - conv3x3_pkg::RSP_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Result outputs.
   assign rsp_valid          = count_ff != '0;
   assign rsp_filtered_value = fifo_ff[rd_ptr_ff].filtered_value;
   assign rsp_out_column     = fifo_ff[rd_ptr_ff].out_column;
   assign rsp_out_row        = fifo_ff[rd_ptr_ff].out_row;
   assign rsp_frame_last     = fifo_ff[rd_ptr_ff].frame_last;

   // The space reservation must keep the queue from ever overflowing.
   assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (count_ff == conv3x3_pkg::RSP_CNT_W'(conv3x3_pkg::RSP_DEPTH))))
      else $error("result queue overflow");

   // The end of a frame always comes with a result.
   assert property (@(posedge clock) disable iff (reset)
      (v4_ff && s4_ctrl_ff.last) |-> s4_ctrl_ff.emit)
      else $error("frame end without a result");

   // The final request of a frame rewinds every position counter.
   assert property (@(posedge clock) disable iff (reset)
      (accept && ctrl0.last) |=>
         (in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("position counters not rewound after frame end");

endmodule
